@@ src/rtp_pkg.sv @@
package rtp_pkg;

  localparam int COORD_WIDTH = 16;
  localparam int ITERATIONS  = 16;
  localparam int GUARD_BITS  = 8;
  localparam int OUT_W       = 16;
  localparam int ANGLE_W     = 32;
  localparam int ATAN_LEN    = 24;
  localparam int SHIFT_W     = $clog2(ATAN_LEN);

  // datapath: coordinate, guard bits, cordic growth and sign
  localparam int DW          = COORD_WIDTH + GUARD_BITS + 2;
  localparam int XF_W        = DW - 1;
  localparam int INV_GAIN_W  = 24;
  localparam int PROD_W      = XF_W + INV_GAIN_W;
  localparam int MAG_SHIFT   = GUARD_BITS + INV_GAIN_W;
  localparam int QUOT_W      = PROD_W + 1 - MAG_SHIFT;

  localparam logic [INV_GAIN_W-1:0] INV_GAIN   = INV_GAIN_W'(10188012);
  localparam logic [63:0]           MAG_LIMIT  = 64'd1 << (GUARD_BITS + 18);
  localparam logic [ANGLE_W-1:0]    HALF_TURN  = ANGLE_W'(32'h8000_0000);
  localparam logic [ANGLE_W-1:0]    ANGLE_RND  = ANGLE_W'(32'h0000_8000);
  localparam logic [OUT_W-1:0]      MAG_MAX    = '1;

  localparam logic [OUT_W-1:0] ANG_POS_X = OUT_W'(0);
  localparam logic [OUT_W-1:0] ANG_POS_Y = OUT_W'(16384);
  localparam logic [OUT_W-1:0] ANG_NEG_X = OUT_W'(32768);
  localparam logic [OUT_W-1:0] ANG_NEG_Y = OUT_W'(49152);

  localparam logic [ANGLE_W-1:0] ATAN_TURNS [ATAN_LEN] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  typedef struct packed {
    logic                    spec;
    logic [OUT_W-1:0]        spec_angle;
    logic [OUT_W-1:0]        spec_mag;
    logic signed [DW-1:0]    x;
    logic signed [DW-1:0]    y;
    logic [ANGLE_W-1:0]      z;
  } cell_data_t;

endpackage

@@ src/rtp_if.sv @@
interface rtp_in_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [rtp_pkg::COORD_WIDTH-1:0] x_coord;
  logic signed [rtp_pkg::COORD_WIDTH-1:0] y_coord;

  modport source (output valid, x_coord, y_coord, input ready);
  modport sink   (input valid, x_coord, y_coord, output ready);
endinterface

interface rtp_out_if;
  logic                       valid;
  logic                       ready;
  logic [rtp_pkg::OUT_W-1:0]  angle;
  logic [rtp_pkg::OUT_W-1:0]  magnitude;

  modport source (output valid, angle, magnitude, input ready);
  modport sink   (input valid, angle, magnitude, output ready);
endinterface

@@ src/rtp_prerot.sv @@
module rtp_prerot (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   valid_i,
  output logic                                   ready_o,
  input  logic signed [rtp_pkg::COORD_WIDTH-1:0] x_i,
  input  logic signed [rtp_pkg::COORD_WIDTH-1:0] y_i,
  output logic                                   valid_o,
  input  logic                                   ready_i,
  output rtp_pkg::cell_data_t                    data_o
);

  logic                          valid_r;
  rtp_pkg::cell_data_t           data_r;
  rtp_pkg::cell_data_t           data_nxt;
  logic signed [rtp_pkg::DW-1:0] xe;
  logic signed [rtp_pkg::DW-1:0] ye;
  logic [rtp_pkg::COORD_WIDTH:0] abs_v;
  logic                          x_zero;
  logic                          y_zero;

  assign ready_o = !valid_r || ready_i;
  assign valid_o = valid_r;
  assign data_o  = data_r;

  assign xe     = rtp_pkg::DW'(x_i);
  assign ye     = rtp_pkg::DW'(y_i);
  assign x_zero = (x_i == '0);
  assign y_zero = (y_i == '0);

  always_comb begin
    // axis magnitude comes from the nonzero coordinate
    if (x_zero) begin
      abs_v = y_i[rtp_pkg::COORD_WIDTH-1] ? (rtp_pkg::COORD_WIDTH+1)'(-ye)
                                          : (rtp_pkg::COORD_WIDTH+1)'(ye);
    end else begin
      abs_v = x_i[rtp_pkg::COORD_WIDTH-1] ? (rtp_pkg::COORD_WIDTH+1)'(-xe)
                                          : (rtp_pkg::COORD_WIDTH+1)'(xe);
    end

    data_nxt.spec     = x_zero || y_zero;
    data_nxt.spec_mag = (64'(abs_v) > 64'(rtp_pkg::MAG_MAX)) ? rtp_pkg::MAG_MAX
                                                            : rtp_pkg::OUT_W'(abs_v);
    priority if (x_zero && !y_zero && !y_i[rtp_pkg::COORD_WIDTH-1]) begin
      data_nxt.spec_angle = rtp_pkg::ANG_POS_Y;
    end else if (x_zero && !y_zero) begin
      data_nxt.spec_angle = rtp_pkg::ANG_NEG_Y;
    end else if (y_zero && x_i[rtp_pkg::COORD_WIDTH-1]) begin
      data_nxt.spec_angle = rtp_pkg::ANG_NEG_X;
    end else begin
      data_nxt.spec_angle = rtp_pkg::ANG_POS_X;
    end

    // left half plane: turn by a half turn
    if (x_i[rtp_pkg::COORD_WIDTH-1]) begin
      data_nxt.x = (-xe) <<< rtp_pkg::GUARD_BITS;
      data_nxt.y = (-ye) <<< rtp_pkg::GUARD_BITS;
      data_nxt.z = rtp_pkg::HALF_TURN;
    end else begin
      data_nxt.x = xe <<< rtp_pkg::GUARD_BITS;
      data_nxt.y = ye <<< rtp_pkg::GUARD_BITS;
      data_nxt.z = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      data_r <= data_nxt;
    end
  end

endmodule

@@ src/rtp_cell.sv @@
module rtp_cell (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [rtp_pkg::SHIFT_W-1:0]       shift_i,
  input  logic [rtp_pkg::ANGLE_W-1:0]       atan_i,
  input  logic                              valid_i,
  output logic                              ready_o,
  input  rtp_pkg::cell_data_t               data_i,
  output logic                              valid_o,
  input  logic                              ready_i,
  output rtp_pkg::cell_data_t               data_o
);

  logic                          valid_r;
  rtp_pkg::cell_data_t           data_r;
  rtp_pkg::cell_data_t           data_nxt;
  logic signed [rtp_pkg::DW-1:0] xs;
  logic signed [rtp_pkg::DW-1:0] ys;

  assign ready_o = !valid_r || ready_i;
  assign valid_o = valid_r;
  assign data_o  = data_r;

  assign xs = data_i.x >>> shift_i;
  assign ys = data_i.y >>> shift_i;

  always_comb begin
    data_nxt = data_i;
    // zero residual turns like a negative one
    if (data_i.y > 0) begin
      data_nxt.x = data_i.x + ys;
      data_nxt.y = data_i.y - xs;
      data_nxt.z = data_i.z + atan_i;
    end else begin
      data_nxt.x = data_i.x - ys;
      data_nxt.y = data_i.y + xs;
      data_nxt.z = data_i.z - atan_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      data_r <= data_nxt;
    end
  end

endmodule

@@ src/rtp_mag.sv @@
module rtp_mag (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        valid_i,
  output logic                        ready_o,
  input  rtp_pkg::cell_data_t         data_i,
  output logic                        valid_o,
  input  logic                        ready_i,
  output logic [rtp_pkg::OUT_W-1:0]   angle_o,
  output logic [rtp_pkg::OUT_W-1:0]   magnitude_o
);

  // stage one: gain multiply
  logic                             mul_valid_r;
  logic                             mul_ready;
  logic [rtp_pkg::PROD_W-1:0]       prod_r;
  logic                             over_r;
  logic                             spec_r;
  logic [rtp_pkg::OUT_W-1:0]        spec_mag_r;
  logic [rtp_pkg::OUT_W-1:0]        mul_angle_r;
  logic [rtp_pkg::XF_W-1:0]         xf;
  logic [rtp_pkg::ANGLE_W-1:0]      z_rnd;

  // stage two: round, saturate, output register
  logic                             out_valid_r;
  logic [rtp_pkg::OUT_W-1:0]        angle_r;
  logic [rtp_pkg::OUT_W-1:0]        mag_r;
  logic [rtp_pkg::OUT_W-1:0]        mag_nxt;
  logic [rtp_pkg::PROD_W:0]         rnd_sum;
  logic [rtp_pkg::QUOT_W-1:0]       quot;

  assign mul_ready = !out_valid_r || ready_i;
  assign ready_o   = !mul_valid_r || mul_ready;

  assign xf    = data_i.x[rtp_pkg::DW-1] ? '0 : data_i.x[rtp_pkg::XF_W-1:0];
  assign z_rnd = data_i.z + rtp_pkg::ANGLE_RND;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_valid_r <= 1'b0;
    end else if (ready_o) begin
      mul_valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      prod_r      <= rtp_pkg::PROD_W'(xf) * rtp_pkg::PROD_W'(rtp_pkg::INV_GAIN);
      over_r      <= 64'(xf) > rtp_pkg::MAG_LIMIT;
      spec_r      <= data_i.spec;
      spec_mag_r  <= data_i.spec_mag;
      mul_angle_r <= data_i.spec ? data_i.spec_angle
                                 : z_rnd[rtp_pkg::ANGLE_W-1 -: rtp_pkg::OUT_W];
    end
  end

  assign rnd_sum = (rtp_pkg::PROD_W+1)'(prod_r)
                 + ((rtp_pkg::PROD_W+1)'(1) << (rtp_pkg::MAG_SHIFT - 1));
  assign quot    = rnd_sum[rtp_pkg::PROD_W:rtp_pkg::MAG_SHIFT];

  always_comb begin
    priority if (spec_r) begin
      mag_nxt = spec_mag_r;
    end else if (over_r || (64'(quot) > 64'(rtp_pkg::MAG_MAX))) begin
      mag_nxt = rtp_pkg::MAG_MAX;
    end else begin
      mag_nxt = rtp_pkg::OUT_W'(quot);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (mul_ready) begin
      out_valid_r <= mul_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mul_ready && mul_valid_r) begin
      angle_r <= mul_angle_r;
      mag_r   <= mag_nxt;
    end
  end

  assign valid_o     = out_valid_r;
  assign angle_o     = angle_r;
  assign magnitude_o = mag_r;

endmodule

@@ src/rectangular_to_polar_core.sv @@
// Rectangular to polar converter. Each accepted item (x_coord, y_coord) yields one item with
// the angle (65536 = one turn, range 0 to 2pi) and the gain-corrected, rounded magnitude.
// Points on an axis and the origin are answered exactly. A new item is taken every clock while
// the output is not stalled. The pipeline has one input stage for the axis cases and the
// half-turn of the left half plane, one cell per CORDIC micro-rotation, one gain multiply
// stage and one output register. Every stage holds its item under backpressure and empty
// stages fill up, so throughput follows the downstream ready.
module rectangular_to_polar_core (
  input  logic      clk,
  input  logic      rst_n,
  rtp_in_if.sink    in_item,
  rtp_out_if.source out_item
);

  logic                 cell_valid [rtp_pkg::ITERATIONS+1];
  logic                 cell_ready [rtp_pkg::ITERATIONS+1];
  rtp_pkg::cell_data_t  cell_data  [rtp_pkg::ITERATIONS+1];

  rtp_prerot u_prerot (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (in_item.valid),
    .ready_o (in_item.ready),
    .x_i     (in_item.x_coord),
    .y_i     (in_item.y_coord),
    .valid_o (cell_valid[0]),
    .ready_i (cell_ready[0]),
    .data_o  (cell_data[0])
  );

  for (genvar i = 0; i < rtp_pkg::ITERATIONS; i++) begin : g_cell
    rtp_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .shift_i (rtp_pkg::SHIFT_W'(i)),
      .atan_i  (rtp_pkg::ATAN_TURNS[i]),
      .valid_i (cell_valid[i]),
      .ready_o (cell_ready[i]),
      .data_i  (cell_data[i]),
      .valid_o (cell_valid[i+1]),
      .ready_i (cell_ready[i+1]),
      .data_o  (cell_data[i+1])
    );
  end

  rtp_mag u_mag (
    .clk         (clk),
    .rst_n       (rst_n),
    .valid_i     (cell_valid[rtp_pkg::ITERATIONS]),
    .ready_o     (cell_ready[rtp_pkg::ITERATIONS]),
    .data_i      (cell_data[rtp_pkg::ITERATIONS]),
    .valid_o     (out_item.valid),
    .ready_i     (out_item.ready),
    .angle_o     (out_item.angle),
    .magnitude_o (out_item.magnitude)
  );

`ifndef ASSERT_OFF
  localparam int STAGES = rtp_pkg::ITERATIONS + 3;
  localparam int CNT_W  = $clog2(STAGES + 1);

  logic [CNT_W-1:0] inflight_r;
  logic             in_acc;
  logic             out_acc;

  assign in_acc  = in_item.valid && in_item.ready;
  assign out_acc = out_item.valid && out_item.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= '0;
    end else if (in_acc && !out_acc) begin
      inflight_r <= inflight_r + CNT_W'(1);
    end else if (out_acc && !in_acc) begin
      inflight_r <= inflight_r - CNT_W'(1);
    end
  end

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_item.valid)
    else $error("result valid after reset");

  a_no_invented_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_item.valid |-> (inflight_r != '0))
    else $error("result without an item in flight");

  a_occupancy_bound: assert property (@(posedge clk) disable iff (!rst_n)
    inflight_r <= CNT_W'(STAGES))
    else $error("more items in flight than stages");

  a_empty_out_takes_in: assert property (@(posedge clk) disable iff (!rst_n)
    !out_item.valid |-> in_item.ready)
    else $error("input stalled while output is empty");

  a_mag_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_item.valid |-> (out_item.magnitude <= rtp_pkg::OUT_W'(46341)))
    else $error("magnitude out of range");
`endif

endmodule
